>>> hdl/lmcm_pkg.sv
// shared constants, types and chip mapping for the led matrix command mapper
package lmcm_pkg;

   // data bytes that follow a line transfer command, green half then red half
   localparam int LINE_BYTES = 128;
   localparam int LINE_HALF  = LINE_BYTES / 2;

   // command bits, highest priority first
   localparam int CMD_BIT_COLUMN   = 7;
   localparam int CMD_BIT_LINE     = 6;
   localparam int CMD_BIT_CLEAR    = 5;
   localparam int CMD_BIT_BRIGHT   = 4;
   localparam int CMD_BIT_TRANSFER = 3;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_CURSOR = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // base chip of a 16-column block
   function automatic logic [2:0] chip_of_block(input logic [2:0] block);
      logic [2:0] chip;
      unique case (block)
         3'd0, 3'd4: chip = 3'd0;
         3'd1, 3'd5: chip = 3'd1;
         3'd2, 3'd6: chip = 3'd4;
         3'd3, 3'd7: chip = 3'd5;
         default:    chip = 3'd0;
      endcase
      return chip;
   endfunction

   // odd lines sit on the chips two above the even ones
   function automatic logic [2:0] chip_of(input logic [2:0] block, input logic odd_line);
      return chip_of_block(block) + {odd_line, 1'b0};
   endfunction

endpackage

>>> hdl/lmcm_if.sv
// request and response channel interfaces of the led matrix command mapper

interface lmcm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] host_byte;

   modport source (output valid, output host_byte, input ready);
   modport sink   (input valid, input host_byte, output ready);
endinterface

interface lmcm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [1:0] row_group;
   logic [2:0] chip;
   logic [5:0] nibble_address;
   logic [7:0] pixel_data;
   logic       last_of_line;

   modport source (output valid, output kind, output row_group, output chip,
                   output nibble_address, output pixel_data, output last_of_line,
                   input ready);
   modport sink   (input valid, input kind, input row_group, input chip,
                   input nibble_address, input pixel_data, input last_of_line,
                   output ready);
endinterface

>>> hdl/led_matrix_command_mapper_unit.sv
// top level: decodes host bytes into addressed writes for the led matrix drivers

// Each request is one host byte and gives exactly one response, in the cycle
// after it is taken. A new request is accepted every cycle, as long as the
// response register is empty or its response is taken in that same cycle, so
// the sustained rate is one request per cycle; the single response register is
// what sets both the latency and the stall behaviour. Outside a line transfer
// a byte is decoded as a command by bit priority (set column, set line, clear,
// brightness, line transfer, single data). After a line transfer command the
// next LINE_BYTES bytes are taken as raw pixel data whatever their value, the
// first half green and the second half red, each mapped to a row group, chip
// and nibble address. There is no clearing pass after reset.
module led_matrix_command_mapper_unit
   import lmcm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   lmcm_req_if.sink     req_channel,
   lmcm_rsp_if.source   rsp_channel
);

   // decoder state
   logic       collecting_ff, collecting_in;
   logic [6:0] byte_count_ff, byte_count_in;
   logic [2:0] transfer_line_ff, transfer_line_in;
   logic [6:0] cursor_column_ff, cursor_column_in;
   logic [2:0] cursor_line_ff, cursor_line_in;

   // response register
   logic       rsp_valid_ff;
   kind_type   kind_ff, kind_in;
   logic [1:0] row_group_ff, row_group_in;
   logic [2:0] chip_ff, chip_in;
   logic [5:0] nibble_address_ff, nibble_address_in;
   logic [7:0] pixel_data_ff, pixel_data_in;
   logic       last_of_line_ff, last_of_line_in;

   logic       req_fire;
   logic [7:0] host_byte;

   // data byte mapping
   logic       data_red;
   logic       data_last;
   logic [5:0] data_col;

   // cursor mapping, on the cursor as it stands after the command
   logic [6:0] cur_col;
   logic [2:0] cur_line;

   // a response slot frees up when empty or drained this cycle
   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;
   assign req_fire          = req_channel.valid && req_channel.ready;
   assign host_byte         = req_channel.host_byte;

   assign data_red  = {1'b0, byte_count_ff} >= 8'(LINE_HALF);
   assign data_col  = data_red ? 6'(byte_count_ff - 7'(LINE_HALF)) : byte_count_ff[5:0];
   assign data_last = {1'b0, byte_count_ff} >= 8'(LINE_BYTES - 1);

   always_comb begin
      collecting_in     = collecting_ff;
      byte_count_in     = byte_count_ff;
      transfer_line_in  = transfer_line_ff;
      cursor_column_in  = cursor_column_ff;
      cursor_line_in    = cursor_line_ff;

      kind_in           = KIND_NONE;
      row_group_in      = 2'd0;
      chip_in           = 3'd0;
      nibble_address_in = 6'd0;
      pixel_data_in     = 8'd0;
      last_of_line_in   = 1'b0;

      cur_col  = cursor_column_ff;
      cur_line = cursor_line_ff;

      if (collecting_ff) begin
         // every byte is data here, even one that looks like a command
         kind_in           = KIND_PIXEL;
         row_group_in      = transfer_line_ff[2:1];
         chip_in           = chip_of({1'b0, data_col[5:4]}, transfer_line_ff[0]);
         nibble_address_in = {data_red, data_col[3:0], 1'b0};
         pixel_data_in     = host_byte;
         last_of_line_in   = data_last;
         if (data_last) begin
            collecting_in = 1'b0;
            byte_count_in = 7'd0;
         end else begin
            byte_count_in = byte_count_ff + 7'd1;
         end
      end else begin
         priority if (host_byte[CMD_BIT_COLUMN]) begin
            cur_col          = host_byte[6:0];
            cursor_column_in = host_byte[6:0];
            kind_in          = KIND_CURSOR;
         end else if (host_byte[CMD_BIT_LINE]) begin
            cur_line         = host_byte[2:0];
            cursor_line_in   = host_byte[2:0];
            kind_in          = KIND_CURSOR;
         end else if (host_byte[CMD_BIT_CLEAR]) begin
            cursor_column_in = 7'd0;
            cursor_line_in   = 3'd0;
            kind_in          = KIND_CLEAR;
         end else if (host_byte[CMD_BIT_BRIGHT]) begin
            // brightness is not acted on
            kind_in          = KIND_NONE;
         end else if (host_byte[CMD_BIT_TRANSFER]) begin
            transfer_line_in = host_byte[2:0];
            collecting_in    = 1'b1;
            byte_count_in    = 7'd0;
         end else begin
            // single data and anything else
            kind_in          = KIND_NONE;
         end

         if (kind_in == KIND_CURSOR) begin
            // upper 64 columns address the red plane
            row_group_in      = cur_line[2:1];
            chip_in           = chip_of(cur_col[6:4], cur_line[0]);
            nibble_address_in = {cur_col[6], cur_col[3:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff    <= 1'b0;
         byte_count_ff    <= 7'd0;
         transfer_line_ff <= 3'd0;
         cursor_column_ff <= 7'd0;
         cursor_line_ff   <= 3'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (req_fire) begin
            collecting_ff    <= collecting_in;
            byte_count_ff    <= byte_count_in;
            transfer_line_ff <= transfer_line_in;
            cursor_column_ff <= cursor_column_in;
            cursor_line_ff   <= cursor_line_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_channel.ready) begin
            rsp_valid_ff     <= 1'b0;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff           <= kind_in;
         row_group_ff      <= row_group_in;
         chip_ff           <= chip_in;
         nibble_address_ff <= nibble_address_in;
         pixel_data_ff     <= pixel_data_in;
         last_of_line_ff   <= last_of_line_in;
      end
   end

   assign rsp_channel.valid          = rsp_valid_ff;
   assign rsp_channel.kind           = kind_ff;
   assign rsp_channel.row_group      = row_group_ff;
   assign rsp_channel.chip           = chip_ff;
   assign rsp_channel.nibble_address = nibble_address_ff;
   assign rsp_channel.pixel_data     = pixel_data_ff;
   assign rsp_channel.last_of_line   = last_of_line_ff;

   // the final data byte of a line ends collection
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && collecting_ff && data_last) |=> !collecting_ff)
      else $error("collection did not end after last data byte");

   // end of line is flagged only on pixel writes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_of_line_ff) |-> (kind_ff == KIND_PIXEL))
      else $error("last_of_line on a non-pixel response");

   // the byte counter never runs past the line length
   assert property (@(posedge clock) disable iff (reset)
      {1'b0, byte_count_ff} < 8'(LINE_BYTES))
      else $error("byte count beyond line length");

   // a taken request always leaves a response behind
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("request taken without a response");

endmodule
